@@ hdl/oale_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Item types, request and status codes, and sequencer states shared by the
// list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

    // Fixed field widths of the request and response items.
    localparam int KEY_W     = 44;
    localparam int REQ_W     = 3;
    localparam int POS_W     = 7;
    localparam int IN_PAY_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int FOUND_W   = 6;
    localparam int LCOUNT_W  = 7;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MISS   = 2'd3;

    // One request item.
    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [POS_W-1:0]    position;
        logic [KEY_W-1:0]    entry_key;
        logic [IN_PAY_W-1:0] entry_payload;
    } oale_req_t;

    // One response item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_index;
        logic [LCOUNT_W-1:0] list_count;
    } oale_rsp_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_WR,
        ST_PUT,
        ST_DN_RD,
        ST_DN_WR,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DONE
    } oale_state_t;

endpackage

@@ hdl/ordered_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// Ordered array list engine
// Fixed-capacity ordered list of key and payload entries with append, insert,
// delete, search and update requests, one response item per request item.
// ----------------------------------------------------------------------------
// The list lives in one entry memory with one write port and one registered
// read port, and a small sequencer walks it one entry at a time. Each moved
// entry is read, then written. Append, update, rejected requests and unknown
// codes move no entries; an insert at position p moves count-p entries and a
// delete at position p moves count-p-1, while a search reads from index 0
// until it hits or reaches the end of the list. The request side is stalled
// from acceptance until the response has been loaded into the output
// register; a response that waits there does not stop the next request from
// being taken. The entry memory needs no clearing after reset, since only
// entries below the current count are ever read.
module ordered_array_list_engine #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  oale_pkg::oale_req_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output oale_pkg::oale_rsp_t rsp_item
);
    import oale_pkg::*;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int ENTRY_W = KEY_W + PAYLOAD_BITS;

    // Sequencer and datapath registers.
    oale_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [CMP_W-1:0]        pos_reg, pos_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [FOUND_W-1:0]      found_reg, found_next;
    oale_rsp_t               rsp_item_reg, rsp_item_next;

    // Entry memory and its ports.
    logic [ENTRY_W-1:0]      mem [CAPACITY];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]      wr_data;

    // Shared index arithmetic and compares.
    logic                    accept;
    logic                    rsp_free;
    logic [CNT_W-1:0]        idx_p1;
    logic [CNT_W-1:0]        idx_m1;
    logic [CNT_W-1:0]        count_m1;
    logic                    full;
    logic [CMP_W-1:0]        req_pos;
    logic                    pos_gt_cnt;
    logic                    pos_ge_cnt;
    logic                    pos_lt_cnt_m1;
    logic                    key_hit;
    logic [PAYLOAD_BITS-1:0] req_payload;

    assign accept   = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        idx_p1        = idx_reg + CNT_W'(1);
        idx_m1        = idx_reg - CNT_W'(1);
        count_m1      = count_reg - CNT_W'(1);
        full          = (count_reg == CNT_W'(CAPACITY));
        req_pos       = CMP_W'(req_item.position);
        pos_gt_cnt    = req_pos > CMP_W'(count_reg);
        pos_ge_cnt    = req_pos >= CMP_W'(count_reg);
        pos_lt_cnt_m1 = req_pos < CMP_W'(count_m1);
        key_hit       = (rd_data_reg[ENTRY_W-1 -: KEY_W] == key_reg);
        req_payload   = PAYLOAD_BITS'(req_item.entry_payload);
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_item.req_type)
                        REQ_INSERT:
                        begin
                            if (full || pos_gt_cnt)
                                state_next = ST_DONE;
                            else if (pos_ge_cnt)
                                state_next = ST_PUT;
                            else
                                state_next = ST_UP_RD;
                        end
                        REQ_DELETE:
                        begin
                            if (!pos_ge_cnt && pos_lt_cnt_m1)
                                state_next = ST_DN_RD;
                            else
                                state_next = ST_DONE;
                        end
                        REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                                state_next = ST_DONE;
                            else
                                state_next = ST_SRCH_RD;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_UP_RD:
                state_next = ST_UP_WR;
            ST_UP_WR:
            begin
                if (CMP_W'(idx_m1) > pos_reg)
                    state_next = ST_UP_RD;
                else
                    state_next = ST_PUT;
            end
            ST_PUT:
                state_next = ST_DONE;
            ST_DN_RD:
                state_next = ST_DN_WR;
            ST_DN_WR:
            begin
                if (idx_p1 < count_m1)
                    state_next = ST_DN_RD;
                else
                    state_next = ST_DONE;
            end
            ST_SRCH_RD:
                state_next = ST_SRCH_CMP;
            ST_SRCH_CMP:
            begin
                if (!key_hit && (idx_p1 < count_reg))
                    state_next = ST_SRCH_RD;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memory controls and datapath updates for each state.
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = {key_reg, payload_reg};
        idx_next       = idx_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        payload_next   = payload_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next     = req_pos;
                    key_next     = req_item.entry_key;
                    payload_next = req_payload;
                    status_next  = STAT_OK;
                    found_next   = '0;
                    case (req_item.req_type)
                        REQ_APPEND:
                        begin
                            if (full)
                                status_next = STAT_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = {req_item.entry_key, req_payload};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (full)
                                status_next = STAT_FULL;
                            else if (pos_gt_cnt)
                                status_next = STAT_BADPOS;
                            else
                                idx_next = count_reg;
                        end
                        REQ_DELETE:
                        begin
                            if (pos_ge_cnt)
                                status_next = STAT_BADPOS;
                            else
                            begin
                                idx_next = CNT_W'(req_item.position);
                                // Deleting the last entry needs no moves.
                                if (!pos_lt_cnt_m1)
                                    count_next = count_m1;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            status_next = STAT_MISS;
                            idx_next    = '0;
                        end
                        REQ_UPDATE:
                        begin
                            if (pos_ge_cnt)
                                status_next = STAT_BADPOS;
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = req_pos[IDX_W-1:0];
                                wr_data = {req_item.entry_key, req_payload};
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_m1[IDX_W-1:0];
            end
            ST_UP_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                idx_next = idx_m1;
            end
            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[IDX_W-1:0];
                count_next = count_reg + CNT_W'(1);
            end
            ST_DN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[IDX_W-1:0];
            end
            ST_DN_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                idx_next = idx_p1;
                if (!(idx_p1 < count_m1))
                    count_next = count_m1;
            end
            ST_SRCH_RD:
            begin
                rd_en = 1'b1;
            end
            ST_SRCH_CMP:
            begin
                if (key_hit)
                begin
                    status_next = STAT_OK;
                    found_next  = FOUND_W'(idx_reg);
                end
                else
                    idx_next = idx_p1;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_item_next.status      = status_reg;
                    rsp_item_next.found_index = found_reg;
                    rsp_item_next.list_count  = LCOUNT_W'(count_reg);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        payload_reg  <= payload_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        rsp_item_reg <= rsp_item_next;
    end

    // Entry memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // The entry count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // The entry count moves by at most one per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count jumped");

    // Writes land at or below the current end of the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CNT_W'(wr_addr) <= count_reg))
        else $error("write beyond end of list");

    // While shifting up, the walk stays above the insert position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_RD) |-> (CMP_W'(idx_reg) > pos_reg))
        else $error("insert shift passed its position");

    // An accepted item always starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item not processed");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Ordered array list engine testbench
// Drives append, insert, delete, search and update requests into the list
// engine through the valid/stall request channel, predicts each response
// from a behavioral copy of the list, and checks every response item field
// by field. A directed pass covers the empty list, the field extremes and the
// rejected requests. Random traffic then grows the list to capacity, shrinks
// it to empty and mixes all requests, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import oale_pkg::*;

    localparam int CAP            = 64;
    localparam int SETTLE_CYCLES  = 2 * CAP + 16;
    localparam int DRAIN_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 1730;
    localparam int PHASE_LEN      = 150;
    localparam int IDLE_PCT       = 34;
    localparam int QUIET_FIRST    = 700;
    localparam int QUIET_LAST     = 950;

    localparam logic [REQ_W-1:0]  REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0]  REQ_UNUSED_HI = 3'd7;
    localparam logic [POS_W-1:0]  POS_MAX       = 7'h7F;
    localparam logic [KEY_W-1:0]  KEY_ONES      = 44'hFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0]  KEY_ODD       = 44'hAAA_AAAA_AAAA;
    localparam logic [KEY_W-1:0]  KEY_EVEN      = 44'h555_5555_5555;
    localparam logic [KEY_W-1:0]  KEY_ABSENT    = 44'h000_0012_3457;
    localparam logic [KEY_W-1:0]  KEY_NIBBLES   = 44'hF0F_0F0F_0F0F;

    // Traffic mixes for the random part.
    typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} traffic_mix_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    oale_req_t           req_item  = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    oale_rsp_t           rsp_item;

    // Behavioral copy of the list.
    logic [KEY_W-1:0]    list_keys [CAP];
    logic [IN_PAY_W-1:0] list_payloads [CAP];
    int                  list_len = 0;

    // Responses predicted but not yet seen.
    oale_rsp_t           pending_rsp[$];

    logic [KEY_W-1:0]    key_pool [16];
    int                  req_idle_pct = IDLE_PCT;
    int                  rsp_idle_pct = IDLE_PCT;
    int                  error_count  = 0;
    int                  items_sent   = 0;
    int                  rsp_checked  = 0;
    int                  full_rejects = 0;
    int                  badpos_count = 0;
    int                  search_hits  = 0;
    int                  search_miss  = 0;
    int                  peak_len     = 0;

    ordered_array_list_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    // Clock with a 12 unit period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request item to the list copy and return its response.
    function automatic oale_rsp_t predict_list_op(input oale_req_t r);
        oale_rsp_t res;
        int        pos;
        int        i;
        res = '0;
        pos = int'(r.position);
        case (r.req_type)
            REQ_APPEND:
            begin
                if (list_len >= CAP)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    list_keys[list_len]     = r.entry_key;
                    list_payloads[list_len] = r.entry_payload;
                    list_len++;
                end
            end
            REQ_INSERT:
            begin
                // Fullness takes priority over a bad position.
                if (list_len >= CAP)
                begin
                    res.status = STAT_FULL;
                end
                else if (pos > list_len)
                begin
                    res.status = STAT_BADPOS;
                end
                else
                begin
                    for (i = list_len; i > pos; i--)
                    begin
                        list_keys[i]     = list_keys[i-1];
                        list_payloads[i] = list_payloads[i-1];
                    end
                    list_keys[pos]     = r.entry_key;
                    list_payloads[pos] = r.entry_payload;
                    list_len++;
                end
            end
            REQ_DELETE:
            begin
                if (pos >= list_len)
                begin
                    res.status = STAT_BADPOS;
                end
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                    begin
                        list_keys[i]     = list_keys[i+1];
                        list_payloads[i] = list_payloads[i+1];
                    end
                    list_len--;
                end
            end
            REQ_SEARCH:
            begin
                // The lowest matching index wins.
                res.status = STAT_MISS;
                for (i = 0; i < list_len; i++)
                begin
                    if (list_keys[i] == r.entry_key)
                    begin
                        res.status      = STAT_OK;
                        res.found_index = i[FOUND_W-1:0];
                        break;
                    end
                end
            end
            REQ_UPDATE:
            begin
                if (pos >= list_len)
                begin
                    res.status = STAT_BADPOS;
                end
                else
                begin
                    list_keys[pos]     = r.entry_key;
                    list_payloads[pos] = r.entry_payload;
                end
            end
            default:
            begin
            end
        endcase
        res.list_count = list_len[LCOUNT_W-1:0];

        // Track what the run has reached.
        if (res.status == STAT_FULL)
        begin
            full_rejects++;
        end
        if (res.status == STAT_BADPOS)
        begin
            badpos_count++;
        end
        if (r.req_type == REQ_SEARCH && res.status == STAT_OK)
        begin
            search_hits++;
        end
        if (res.status == STAT_MISS)
        begin
            search_miss++;
        end
        if (list_len > peak_len)
        begin
            peak_len = list_len;
        end
        return res;
    endfunction

    // Offer one request item, idling at random first, and wait for acceptance.
    task automatic send_req(input logic [REQ_W-1:0] kind, input int pos,
                            input logic [KEY_W-1:0] key,
                            input logic [IN_PAY_W-1:0] payload);
        oale_req_t r;
        r.req_type      = kind;
        r.position      = pos[POS_W-1:0];
        r.entry_key     = key;
        r.entry_payload = payload;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= r;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        pending_rsp.push_back(predict_list_op(r));
        items_sent++;
    endtask

    // Check each accepted response item and stall the response side at random.
    always @(posedge clk)
    begin : rsp_checker
        oale_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_checked++;
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response item: status %0d index %0d count %0d",
                       rsp_item.status, rsp_item.found_index, rsp_item.list_count);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_item.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                    error_count++;
                end
                if (rsp_item.found_index !== want.found_index)
                begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, rsp_item.found_index);
                    error_count++;
                end
                if (rsp_item.list_count !== want.list_count)
                begin
                    $error("list_count: expected %0d, got %0d",
                           want.list_count, rsp_item.list_count);
                    error_count++;
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end

    // On the empty list a search misses, and delete, update and an insert at position 1 are rejected.
    task automatic test_empty_list();
        send_req(REQ_SEARCH, 0, KEY_ONES, '0);
        send_req(REQ_DELETE, 0, KEY_ONES, '1);
        send_req(REQ_UPDATE, 0, KEY_ODD, '1);
        send_req(REQ_INSERT, 1, KEY_EVEN, '1);
    endtask

    // Inserts at the front, middle and end and at a bad position, appends, and a duplicate key.
    task automatic test_insert_append();
        send_req(REQ_INSERT, 0, KEY_ONES, 32'hFFFF_FFFF);
        send_req(REQ_APPEND, 0, '0, '0);
        send_req(REQ_INSERT, 2, KEY_ODD, 32'hA5A5_5A5A);
        send_req(REQ_INSERT, POS_MAX, KEY_EVEN, 32'h5A5A_A5A5);
        send_req(REQ_INSERT, 1, KEY_EVEN, 32'h0000_0001);
        send_req(REQ_APPEND, POS_MAX, KEY_ONES, 32'h8000_0000);
    endtask

    // Hits at the front and in the middle, the lowest of two duplicates, and a miss.
    task automatic test_search();
        send_req(REQ_SEARCH, 0, KEY_ONES, '0);
        send_req(REQ_SEARCH, POS_MAX, '0, '1);
        send_req(REQ_SEARCH, 0, KEY_ABSENT, '0);
        send_req(REQ_SEARCH, 0, KEY_ODD, '0);
    endtask

    // Overwrite the last entry, update past the end, delete the first and the last, delete past the end, then search.
    task automatic test_update_delete();
        send_req(REQ_UPDATE, list_len - 1, KEY_NIBBLES, 32'h0F0F_F0F0);
        send_req(REQ_UPDATE, list_len, KEY_ODD, '1);
        send_req(REQ_UPDATE, POS_MAX, KEY_ODD, '1);
        send_req(REQ_DELETE, 0, '0, '0);
        send_req(REQ_DELETE, list_len - 1, '0, '0);
        send_req(REQ_DELETE, CAP, '0, '0);
        send_req(REQ_SEARCH, 0, '0, '0);
    endtask

    // Unused request codes leave the list alone.
    task automatic test_unknown_codes();
        send_req(REQ_UNUSED_LO, 0, KEY_ONES, '1);
        send_req(REQ_UNUSED_LO + 3'd1, POS_MAX, '0, '0);
        send_req(REQ_UNUSED_HI, 1, KEY_EVEN, 32'hDEAD_BEEF);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        if ($urandom_range(99) < 75)
        begin
            return key_pool[$urandom_range(15)];
        end
        return wide[KEY_W-1:0];
    endfunction

    // Mostly in-range positions, with some anywhere in the field.
    function automatic int pick_pos(input int top);
        if (top >= 0 && $urandom_range(99) < 85)
        begin
            return $urandom_range(top);
        end
        return $urandom_range(int'(POS_MAX));
    endfunction

    // Random traffic cycling through growth, balanced and shrinking mixes.
    task automatic test_random_traffic(input int n_items);
        traffic_mix_t     mix;
        int               counted;
        int               roll;
        int               w_app;
        int               w_ins;
        int               w_del;
        int               w_srch;
        int               w_upd;
        logic [KEY_W-1:0] key;
        logic [31:0]      payload;
        counted = 0;
        while (counted < n_items)
        begin
            // One long stretch runs with no idling on either side.
            if (counted >= QUIET_FIRST && counted < QUIET_LAST)
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            else
            begin
                req_idle_pct = IDLE_PCT;
                rsp_idle_pct = IDLE_PCT;
            end
            mix = traffic_mix_t'((counted / PHASE_LEN) % 3);
            case (mix)
                MIX_GROW:
                begin
                    w_app = 35; w_ins = 35; w_del = 8; w_srch = 12; w_upd = 7;
                end
                MIX_SHRINK:
                begin
                    w_app = 8; w_ins = 8; w_del = 55; w_srch = 17; w_upd = 9;
                end
                default:
                begin
                    w_app = 20; w_ins = 20; w_del = 20; w_srch = 22; w_upd = 15;
                end
            endcase
            key     = pick_key();
            payload = $urandom;
            roll    = $urandom_range(99);
            if (roll < w_app)
            begin
                send_req(REQ_APPEND, $urandom_range(int'(POS_MAX)), key, payload);
                counted++;
            end
            else if (roll < w_app + w_ins)
            begin
                send_req(REQ_INSERT, pick_pos(list_len), key, payload);
                counted++;
            end
            else if (roll < w_app + w_ins + w_del)
            begin
                send_req(REQ_DELETE, pick_pos(list_len - 1), key, payload);
                counted++;
            end
            else if (roll < w_app + w_ins + w_del + w_srch)
            begin
                send_req(REQ_SEARCH, $urandom_range(int'(POS_MAX)), key, payload);
                counted++;
            end
            else if (roll < w_app + w_ins + w_del + w_srch + w_upd)
            begin
                send_req(REQ_UPDATE, pick_pos(list_len - 1), key, payload);
                counted++;
            end
            else
            begin
                send_req(REQ_W'($urandom_range(int'(REQ_UNUSED_HI), int'(REQ_UNUSED_LO))),
                         $urandom_range(int'(POS_MAX)), key, payload);
            end
        end
        req_idle_pct = IDLE_PCT;
        rsp_idle_pct = IDLE_PCT;
    endtask

    // Overall time limit.
    initial
    begin
        #36000000;
        $display("tb failed");
        $finish;
    end

    initial
    begin : run_tests
        int i;
        int waited;
        logic [63:0] wide;
        key_pool[0] = '0;
        key_pool[1] = KEY_ONES;
        for (i = 2; i < 16; i++)
        begin
            wide        = {$urandom, $urandom};
            key_pool[i] = wide[KEY_W-1:0];
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_insert_append();
        test_search();
        test_update_delete();
        test_unknown_codes();
        test_random_traffic(RANDOM_ITEMS);

        // Let the last responses drain.
        req_valid <= 1'b0;
        waited = 0;
        while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $error("%0d response items never arrived", pending_rsp.size());
            error_count += pending_rsp.size();
        end

        $display("Sent %0d requests and checked %0d responses; peak length %0d.",
                 items_sent, rsp_checked, peak_len);
        $display("Saw %0d full rejects, %0d bad positions, %0d search hits, %0d misses.",
                 full_rejects, badpos_count, search_hits, search_miss);
        if (error_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
